/* src/dsparse_pkg.sv */
// Types, character codes and unit constants for the duration string parser.
package dsparse_pkg;

   typedef logic [7:0]  char_type;
   typedef logic [63:0] secs64_type;
   typedef logic [31:0] secs32_type;
   typedef logic [29:0] nano_type;

   localparam char_type CHAR_0 = 8'h30;
   localparam char_type CHAR_9 = 8'h39;
   localparam char_type CHAR_W = 8'h77;
   localparam char_type CHAR_D = 8'h64;
   localparam char_type CHAR_H = 8'h68;
   localparam char_type CHAR_M = 8'h6d;
   localparam char_type CHAR_S = 8'h73;

   localparam int UNIT_COUNT  = 5;
   localparam int UNIT_WEEK   = 0;
   localparam int UNIT_DAY    = 1;
   localparam int UNIT_HOUR   = 2;
   localparam int UNIT_MINUTE = 3;
   localparam int UNIT_SECOND = 4;

   localparam secs32_type SECS_PER_WEEK   = 32'd604800;
   localparam secs32_type SECS_PER_DAY    = 32'd86400;
   localparam secs32_type SECS_PER_HOUR   = 32'd3600;
   localparam secs32_type SECS_PER_MINUTE = 32'd60;
   localparam secs32_type SECS_PER_SECOND = 32'd1;

endpackage

/* src/duration_string_parser.sv */
// Duration string parser: one character word per cycle while req_stall is low, one result word per string.
//
//   channel  direction  handshake            word
//   req      in         req_valid/req_stall  character, last flag, base seconds, base nanos
//   rsp      out        rsp_valid/rsp_stall  result seconds, result nanos, parse error
//
// One character word is taken every cycle while req_stall is low; throughput
// is set by the single character decode and unit multiply stage. After its
// last character is accepted, the result of a string passes through the finish,
// sum and output registers behind the input register. Reset clears the unit
// registers and all valid bits.
// A stalled result holds in the output register while the stages behind it
// keep filling; req_stall rises only when the finish path is full.
module duration_string_parser (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  dsparse_pkg::char_type   req_character,
   input  logic                    req_last,
   input  dsparse_pkg::secs64_type req_base_seconds,
   input  dsparse_pkg::nano_type   req_base_nano,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output dsparse_pkg::secs64_type rsp_result_seconds,
   output dsparse_pkg::nano_type   rsp_result_nano,
   output logic                    rsp_parse_error
);
   import dsparse_pkg::*;

   logic       in_valid_ff;
   char_type   in_char_ff;
   logic       in_last_ff;
   secs64_type in_base_s_ff;
   nano_type   in_base_n_ff;

   secs32_type acc_ff, acc_in;
   secs32_type unit_ff [UNIT_COUNT];
   secs32_type unit_in [UNIT_COUNT];
   logic       err_ff, err_in;

   logic       fin_valid_ff;
   secs32_type fin_unit_ff [UNIT_COUNT];
   logic       fin_err_ff;
   secs64_type fin_base_s_ff;
   nano_type   fin_base_n_ff;

   logic       tot_valid_ff;
   secs32_type tot_sum_ff, tot_sum_in;
   logic       tot_err_ff;
   secs64_type tot_base_s_ff;
   nano_type   tot_base_n_ff;

   logic       rsp_valid_ff;
   secs64_type rsp_seconds_ff;
   nano_type   rsp_nano_ff;
   logic       rsp_err_ff;

   logic rsp_free, tot_free, fin_free, proc, in_free;

   logic                  is_digit;
   logic [UNIT_COUNT-1:0] unit_sel;
   logic [UNIT_COUNT-1:0] unit_nz;
   logic [UNIT_COUNT-1:0] smaller_nz;
   logic [UNIT_COUNT-1:0] unit_write;
   secs32_type            scale;
   secs32_type            product;
   char_type              digit8;
   secs32_type            acc_digit;
   logic                  order_err;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign tot_free  = !tot_valid_ff || rsp_free;
   assign fin_free  = !fin_valid_ff || tot_free;
   assign proc      = in_valid_ff && (!in_last_ff || fin_free);
   assign in_free   = !in_valid_ff || proc;
   assign req_stall = !in_free;

   always_comb begin
      is_digit = 1'b0;
      unit_sel = '0;
      scale    = '0;
      unique case (in_char_ff) inside
         [CHAR_0:CHAR_9]: is_digit = 1'b1;
         CHAR_W: begin
            unit_sel[UNIT_WEEK] = 1'b1;
            scale               = SECS_PER_WEEK;
         end
         CHAR_D: begin
            unit_sel[UNIT_DAY] = 1'b1;
            scale              = SECS_PER_DAY;
         end
         CHAR_H: begin
            unit_sel[UNIT_HOUR] = 1'b1;
            scale               = SECS_PER_HOUR;
         end
         CHAR_M: begin
            unit_sel[UNIT_MINUTE] = 1'b1;
            scale                 = SECS_PER_MINUTE;
         end
         CHAR_S: begin
            unit_sel[UNIT_SECOND] = 1'b1;
            scale                 = SECS_PER_SECOND;
         end
         default: ;
      endcase
   end

   assign product   = acc_ff * scale;
   assign digit8    = in_char_ff - CHAR_0;
   assign acc_digit = {acc_ff[28:0], 3'b000} + {acc_ff[30:0], 1'b0} + {24'd0, digit8};

   always_comb begin
      for (int i = 0; i < UNIT_COUNT; i++) begin
         unit_nz[i] = |unit_ff[i];
      end
      for (int i = 0; i < UNIT_COUNT; i++) begin
         smaller_nz[i] = 1'b0;
         for (int j = 0; j < UNIT_COUNT; j++) begin
            if (j > i) begin
               smaller_nz[i] = smaller_nz[i] | unit_nz[j];
            end
         end
      end
      unit_write = unit_sel & ~smaller_nz;
      order_err  = |(unit_sel & smaller_nz);
      for (int i = 0; i < UNIT_COUNT; i++) begin
         unit_in[i] = unit_write[i] ? product : unit_ff[i];
      end
      if (is_digit) begin
         acc_in = acc_digit;
      end else if (|unit_sel) begin
         acc_in = '0;
      end else begin
         acc_in = acc_ff;
      end
      err_in = err_ff || (is_digit && in_last_ff) || order_err || (!is_digit && !(|unit_sel));
   end

   always_comb begin
      tot_sum_in = '0;
      for (int i = 0; i < UNIT_COUNT; i++) begin
         tot_sum_in = tot_sum_in + fin_unit_ff[i];
      end
   end

   // control and parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         fin_valid_ff <= 1'b0;
         tot_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= '0;
         err_ff       <= 1'b0;
         for (int i = 0; i < UNIT_COUNT; i++) begin
            unit_ff[i] <= '0;
         end
      end else begin
         if (in_free) begin
            in_valid_ff <= req_valid;
         end
         if (proc) begin
            if (in_last_ff) begin
               acc_ff <= '0;
               err_ff <= 1'b0;
               for (int i = 0; i < UNIT_COUNT; i++) begin
                  unit_ff[i] <= '0;
               end
            end else begin
               acc_ff <= acc_in;
               err_ff <= err_in;
               for (int i = 0; i < UNIT_COUNT; i++) begin
                  unit_ff[i] <= unit_in[i];
               end
            end
         end
         if (fin_free) begin
            fin_valid_ff <= proc && in_last_ff;
         end
         if (tot_free) begin
            tot_valid_ff <= fin_valid_ff;
         end
         if (rsp_free) begin
            rsp_valid_ff <= tot_valid_ff;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (in_free) begin
         in_char_ff   <= req_character;
         in_last_ff   <= req_last;
         in_base_s_ff <= req_base_seconds;
         in_base_n_ff <= req_base_nano;
      end
      if (fin_free && proc && in_last_ff) begin
         for (int i = 0; i < UNIT_COUNT; i++) begin
            fin_unit_ff[i] <= unit_in[i];
         end
         fin_err_ff    <= err_in;
         fin_base_s_ff <= in_base_s_ff;
         fin_base_n_ff <= in_base_n_ff;
      end
      if (tot_free && fin_valid_ff) begin
         tot_sum_ff    <= tot_sum_in;
         tot_err_ff    <= fin_err_ff;
         tot_base_s_ff <= fin_base_s_ff;
         tot_base_n_ff <= fin_base_n_ff;
      end
      if (rsp_free && tot_valid_ff) begin
         rsp_err_ff     <= tot_err_ff;
         rsp_seconds_ff <= tot_err_ff ? '0 : tot_base_s_ff - {32'd0, tot_sum_ff};
         rsp_nano_ff    <= tot_err_ff ? '0 : tot_base_n_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_seconds = rsp_seconds_ff;
   assign rsp_result_nano    = rsp_nano_ff;
   assign rsp_parse_error    = rsp_err_ff;

endmodule

/* bench/duration_check_pkg.sv */
// Expected-result tracking for the duration string parser bench.
package duration_check_pkg;
   import dsparse_pkg::*;

   typedef struct {
      secs64_type seconds;
      nano_type   nano;
      logic       parse_error;
   } due_time_type;

   class duration_scoreboard;
      secs32_type   digit_accum;
      secs32_type   unit_secs[UNIT_COUNT];
      bit           error_flag;
      due_time_type times_due[$];
      int           mismatches;

      function new();
         clear_state();
         mismatches = 0;
      endfunction

      function void clear_state();
         digit_accum = '0;
         foreach (unit_secs[k]) unit_secs[k] = '0;
         error_flag = 1'b0;
      endfunction

      function void apply_char(char_type c, logic is_last, secs64_type bs, nano_type bn);
         secs32_type   scale;
         secs32_type   total;
         int           slot;
         int           k;
         bit           smaller_set;
         due_time_type due;
         slot = -1;
         scale = '0;
         if (c >= CHAR_0 && c <= CHAR_9) begin
            digit_accum = digit_accum * secs32_type'(10) + secs32_type'(c - CHAR_0);
            if (is_last) error_flag = 1'b1;
         end else begin
            case (c)
               CHAR_W: begin
                  slot = UNIT_WEEK;
                  scale = SECS_PER_WEEK;
               end
               CHAR_D: begin
                  slot = UNIT_DAY;
                  scale = SECS_PER_DAY;
               end
               CHAR_H: begin
                  slot = UNIT_HOUR;
                  scale = SECS_PER_HOUR;
               end
               CHAR_M: begin
                  slot = UNIT_MINUTE;
                  scale = SECS_PER_MINUTE;
               end
               CHAR_S: begin
                  slot = UNIT_SECOND;
                  scale = SECS_PER_SECOND;
               end
               default: error_flag = 1'b1;
            endcase
            if (slot >= 0) begin
               smaller_set = 1'b0;
               for (k = slot + 1; k < UNIT_COUNT; k++) begin
                  if (unit_secs[k] != '0) smaller_set = 1'b1;
               end
               if (smaller_set) error_flag = 1'b1;
               else unit_secs[slot] = digit_accum * scale;
               digit_accum = '0;
            end
         end
         if (is_last) begin
            if (error_flag) begin
               due = '{seconds: '0, nano: '0, parse_error: 1'b1};
            end else begin
               total = '0;
               for (k = 0; k < UNIT_COUNT; k++) total = total + unit_secs[k];
               due = '{seconds: bs - {32'd0, total}, nano: bn, parse_error: 1'b0};
            end
            times_due.push_back(due);
            clear_state();
         end
      endfunction

      task report_mismatch(string msg);
         $display("mismatch: %s", msg);
         mismatches++;
      endtask

      task check_result(secs64_type s, nano_type n, logic e);
         due_time_type due;
         if (times_due.size() == 0) begin
            report_mismatch($sformatf("result word with nothing expected (s=%h)", s));
            return;
         end
         due = times_due.pop_front();
         if (s !== due.seconds)
            report_mismatch($sformatf("result_seconds got %h want %h", s, due.seconds));
         if (n !== due.nano)
            report_mismatch($sformatf("result_nano got %h want %h", n, due.nano));
         if (e !== due.parse_error)
            report_mismatch($sformatf("parse_error got %b want %b", e, due.parse_error));
      endtask

      function int waiting();
         return times_due.size();
      endfunction
   endclass

endpackage

/* bench/tb_top.sv */
// Top-level bench for the duration string parser: stimulus, response check and run control.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import dsparse_pkg::*;
   import duration_check_pkg::*;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   char_type   req_character;
   logic       req_last;
   secs64_type req_base_seconds;
   nano_type   req_base_nano;
   logic       rsp_valid;
   logic       rsp_stall;
   secs64_type rsp_result_seconds;
   nano_type   rsp_result_nano;
   logic       rsp_parse_error;

   duration_scoreboard sb;
   int items_sent;
   int send_gap_pct;
   int stall_pct;
   int hold_cycles;

   duration_string_parser dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_character      (req_character),
      .req_last           (req_last),
      .req_base_seconds   (req_base_seconds),
      .req_base_nano      (req_base_nano),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_seconds (rsp_result_seconds),
      .rsp_result_nano    (rsp_result_nano),
      .rsp_parse_error    (rsp_parse_error)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #400000;
      $display("tb_top failed");
      $finish;
   end

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0)
            sb.check_result(rsp_result_seconds, rsp_result_nano, rsp_parse_error);
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_cycles--;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   function automatic char_type unit_char(int u);
      case (u)
         UNIT_WEEK:   return CHAR_W;
         UNIT_DAY:    return CHAR_D;
         UNIT_HOUR:   return CHAR_H;
         UNIT_MINUTE: return CHAR_M;
         default:     return CHAR_S;
      endcase
   endfunction

   task automatic send_char(input char_type c, input logic is_last,
                            input secs64_type bs, input nano_type bn);
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_character    <= c;
      req_last         <= is_last;
      req_base_seconds <= bs;
      req_base_nano    <= bn;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.apply_char(c, is_last, bs, bn);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(input string s, input secs64_type bs, input nano_type bn);
      int i;
      for (i = 0; i < s.len(); i++) send_char(char_type'(s[i]), i == s.len() - 1, bs, bn);
   endtask

   task automatic append_number(ref char_type text[$]);
      int ndig;
      int i;
      if ($urandom_range(0, 9) == 0) ndig = $urandom_range(8, 11);
      else ndig = $urandom_range(0, 3);
      for (i = 0; i < ndig; i++) text.push_back(char_type'($urandom_range(CHAR_0, CHAR_9)));
   endtask

   task automatic send_string();
      char_type text[$];
      string    alphabet;
      int       kind;
      int       u;
      int       i;
      int       len;
      alphabet = "0123456789wdhms";
      kind = $urandom_range(0, 99);
      if (kind < 75) begin
         for (u = 0; u < UNIT_COUNT; u++) begin
            if ($urandom_range(0, 1) == 1) begin
               append_number(text);
               text.push_back(unit_char(u));
               if ($urandom_range(0, 9) == 0) begin
                  append_number(text);
                  text.push_back(unit_char(u));
               end
            end
         end
         if (text.size() == 0) begin
            append_number(text);
            text.push_back(CHAR_S);
         end
         if (kind >= 58) begin
            case ($urandom_range(0, 2))
               0: text.push_back(char_type'($urandom_range(CHAR_0, CHAR_9)));
               1: begin
                  append_number(text);
                  text.push_back(unit_char($urandom_range(0, UNIT_COUNT - 1)));
               end
               default: text[$urandom_range(0, text.size() - 1)] = char_type'($urandom());
            endcase
         end
      end else begin
         len = $urandom_range(1, 6);
         for (i = 0; i < len; i++) begin
            if ($urandom_range(0, 1) == 1) text.push_back(char_type'($urandom()));
            else text.push_back(char_type'(alphabet[$urandom_range(0, alphabet.len() - 1)]));
         end
      end
      for (i = 0; i < text.size(); i++)
         send_char(text[i], i == text.size() - 1, {$urandom(), $urandom()},
                   nano_type'($urandom_range(0, 999999999)));
   endtask

   initial begin
      sb = new();
      items_sent = 0;
      send_gap_pct = 0;
      stall_pct = 0;
      hold_cycles = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_character = '0;
      req_last = 1'b0;
      req_base_seconds = '0;
      req_base_nano = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_text("2w3d4h5m6s", '1, nano_type'(999999999));
      send_text("s", '0, '0);
      send_text("7", 64'd12345, nano_type'(5));
      send_char(8'h00, 1'b1, 64'd99, nano_type'(1));
      send_text("1s1m", 64'd1000, nano_type'(2));
      send_text("4294967w", 64'h0000_0000_0000_0001, nano_type'(536870912));

      send_gap_pct = 15;
      stall_pct = 66;
      hold_cycles = 150;
      while (items_sent < 275) send_string();
      send_gap_pct = 66;
      stall_pct = 15;
      while (items_sent < 525) send_string();
      send_gap_pct = 0;
      stall_pct = 0;
      while (items_sent < 775) send_string();
      req_valid <= 1'b0;

      while (sb.waiting() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
